@@ rtl/rgbrle_pkg.sv @@
// Package: shared types and constants of the RGB run-length encoder.
package rgbrle_pkg;

    // Reset value of the run length limit
    localparam logic [7:0] MAX_RUN_RESET = 8'd255;

    // Default depth of the result queue (must be at least 2)
    localparam int QUEUE_DEPTH = 4;

    // One pixel color
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // One emitted run, packed as the output stream carries it
    typedef struct packed {
        logic       final_result;
        logic       closes_line;
        logic [7:0] run_blue;
        logic [7:0] run_green;
        logic [7:0] run_red;
        logic [7:0] run_length;
    } t_result;

    // Results produced by one accepted pixel, in output order
    typedef struct packed {
        logic [1:0] count;
        t_result    slot1;
        t_result    slot0;
    } t_push;

endpackage

@@ rtl/rgbrle_run.sv @@
// Run tracker: holds the open run and forms the results of each pixel.
module rgbrle_run
    import rgbrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_pixel     i_pixel,
    input  logic       i_line_end,
    input  logic [7:0] i_max_run,
    output t_push      o_push
);

    t_pixel     r_open_color;
    logic [7:0] r_open_length;
    t_pixel     n_open_color;
    logic [7:0] n_open_length;

    logic    w_extend;
    logic    w_emit_old;
    t_result w_old_run;
    t_result w_new_run;
    t_pixel  w_run_color;
    logic [7:0] w_run_length;

    // Decide whether the pixel lengthens the open run
    always_comb begin
        w_extend   = (r_open_length != 8'd0) && (i_pixel == r_open_color)
                     && (r_open_length < i_max_run);
        w_emit_old = !w_extend && (r_open_length != 8'd0);
        w_run_color  = w_extend ? r_open_color : i_pixel;
        w_run_length = w_extend ? (r_open_length + 8'd1) : 8'd1;
    end

    // Form the closed run and the run flushed at end of line
    always_comb begin
        w_old_run.run_length   = r_open_length;
        w_old_run.run_red      = r_open_color.red;
        w_old_run.run_green    = r_open_color.green;
        w_old_run.run_blue     = r_open_color.blue;
        w_old_run.closes_line  = 1'b0;
        w_old_run.final_result = !i_line_end;

        w_new_run.run_length   = w_run_length;
        w_new_run.run_red      = w_run_color.red;
        w_new_run.run_green    = w_run_color.green;
        w_new_run.run_blue     = w_run_color.blue;
        w_new_run.closes_line  = 1'b1;
        w_new_run.final_result = 1'b1;

        o_push.slot0 = w_emit_old ? w_old_run : w_new_run;
        o_push.slot1 = w_new_run;
        if (i_accept) begin
            o_push.count = {1'b0, w_emit_old} + {1'b0, i_line_end};
        end else begin
            o_push.count = 2'd0;
        end
    end

    // Advance the open run; end of line leaves no run open
    always_comb begin
        n_open_color  = r_open_color;
        n_open_length = r_open_length;
        if (i_accept) begin
            n_open_color  = w_run_color;
            n_open_length = i_line_end ? 8'd0 : w_run_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_color  <= '0;
            r_open_length <= 8'd0;
        end else begin
            r_open_color  <= n_open_color;
            r_open_length <= n_open_length;
        end
    end

endmodule

@@ rtl/rgbrle_outq.sv @@
// Result queue: takes up to two runs per cycle, one out per ready cycle.
module rgbrle_outq
    import rgbrle_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int PtrW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CntW = $clog2(P_DEPTH + 1);

    t_result r_mem [P_DEPTH];

    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    logic [PtrW-1:0] w_wr_ptr1;
    logic [PtrW-1:0] w_wr_ptr2;
    logic [PtrW-1:0] w_rd_ptr1;
    logic            w_pop;

    // Wrap pointers at the queue depth
    always_comb begin
        w_wr_ptr1 = (r_wr_ptr == PtrW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        w_wr_ptr2 = (w_wr_ptr1 == PtrW'(P_DEPTH - 1)) ? '0 : w_wr_ptr1 + 1'b1;
        w_rd_ptr1 = (r_rd_ptr == PtrW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    assign w_pop    = o_valid && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= CntW'(P_DEPTH - 2));
    assign o_result = r_mem[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        unique case (i_push.count)
            2'd1:    n_wr_ptr = w_wr_ptr1;
            2'd2:    n_wr_ptr = w_wr_ptr2;
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_rd_ptr = w_pop ? w_rd_ptr1 : r_rd_ptr;
        n_count  = r_count + CntW'(i_push.count) - CntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the runs in order
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.slot0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.slot1;
        end
    end

endmodule

@@ rtl/rgb_run_length_encoder.sv @@
// Top level of the RGB run-length encoder.
//
//  Channel   Direction  Payload                                   Handshake
//  s stream  in         tdata red/green/blue, tlast line_end      tvalid/tready
//  m stream  out        tdata length/red/green/blue, tlast
//                       closes_line, tuser final_result           tvalid/tready
//  cfg       in         max_run                                   write enable
//
// One pixel is taken per clock while the queue has room; its runs enter the
// result queue at the same edge that accepts it and the first can leave in
// the next cycle. A pixel at the end of a line can give two runs; the queue
// takes both at the same edge and drains one per cycle while the receiver
// is ready. The input stalls while the queue has fewer than two free entries.
// Reset empties the queue, closes the open run and sets max_run to 255.
module rgb_run_length_encoder
    import rgbrle_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel request in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        i_s_tlast,   // line_end
    // run request out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // run_length, run_red, run_green, run_blue
    output logic        o_m_tlast,   // closes_line
    output logic [0:0]  o_m_tuser,   // final_result
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic [7:0] r_max_run;
    logic       w_accept;
    logic       w_room;
    t_push      w_push;
    t_result    w_result;

    // Hold the run length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run <= MAX_RUN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_run <= i_cfg_wr_data;
        end
    end

    assign o_s_tready = w_room;
    assign w_accept   = i_s_tvalid && w_room;

    rgbrle_run u_run (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_pixel    (t_pixel'(i_s_tdata)),
        .i_line_end (i_s_tlast),
        .i_max_run  (r_max_run),
        .o_push     (w_push)
    );

    rgbrle_outq #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    // Unpack the head run onto the stream
    assign o_m_tdata = {w_result.run_blue, w_result.run_green,
                        w_result.run_red, w_result.run_length};
    assign o_m_tlast = w_result.closes_line;
    assign o_m_tuser = w_result.final_result;

endmodule

@@ sim/rgb_run_length_encoder_tb.sv @@
// Self-checking testbench for the RGB run-length encoder with a run predictor.
`timescale 1ns / 100ps

module rgb_run_length_encoder_tb;
    import rgbrle_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 300;

    // Runs whose value is plain after reset: a lone pixel that ends its line
    localparam t_result RUN_BLACK_ALONE = '{final_result: 1'b1, closes_line: 1'b1,
        run_blue: 8'h00, run_green: 8'h00, run_red: 8'h00, run_length: 8'd1};
    localparam t_result RUN_WHITE_ALONE = '{final_result: 1'b1, closes_line: 1'b1,
        run_blue: 8'hff, run_green: 8'hff, run_red: 8'hff, run_length: 8'd1};

    typedef enum logic {ROW_PIXEL, ROW_MAX_RUN} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       line_end;
        logic [7:0] max_run;
        logic       typed;
        t_result    run;
    } t_row;

    localparam int NUM_ROWS = 25;

    // Directed stimulus: extremes, limit changes, zero limit, lowered limit
    t_row directed_rows [0:NUM_ROWS-1] = '{
        '{ROW_PIXEL,   8'h00, 8'h00, 8'h00, 1'b1, 8'd0,   1'b1, RUN_BLACK_ALONE},
        '{ROW_PIXEL,   8'hff, 8'hff, 8'hff, 1'b1, 8'd0,   1'b1, RUN_WHITE_ALONE},
        '{ROW_PIXEL,   8'h12, 8'h34, 8'h56, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h12, 8'h34, 8'h56, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h12, 8'h34, 8'h56, 1'b0, 8'd0,   1'b0, '0},
        // lower the limit below the open length of three
        '{ROW_MAX_RUN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd1,   1'b0, '0},
        '{ROW_PIXEL,   8'h12, 8'h34, 8'h56, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h12, 8'h34, 8'h56, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'ha5, 8'h5a, 8'hc3, 1'b1, 8'd0,   1'b0, '0},
        // zero limit acts as one
        '{ROW_MAX_RUN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h01, 8'h01, 8'h01, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h01, 8'h01, 8'h01, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_MAX_RUN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd255, 1'b0, '0},
        '{ROW_PIXEL,   8'h80, 8'h00, 8'h00, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h80, 8'h00, 8'h00, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h00, 8'h80, 8'h00, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h00, 8'h00, 8'h80, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_MAX_RUN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd2,   1'b0, '0},
        '{ROW_PIXEL,   8'h7f, 8'h7f, 8'h7f, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h7f, 8'h7f, 8'h7f, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h7f, 8'h7f, 8'h7f, 1'b0, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'h7f, 8'h7f, 8'h7f, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_PIXEL,   8'hfe, 8'hdc, 8'hba, 1'b1, 8'd0,   1'b0, '0},
        '{ROW_MAX_RUN, 8'h00, 8'h00, 8'h00, 1'b0, 8'd255, 1'b0, '0},
        '{ROW_PIXEL,   8'h55, 8'haa, 8'h55, 1'b0, 8'd0,   1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;      // red [7:0], green [15:8], blue [23:16]
    logic        i_s_tlast;      // line_end
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;      // run_length, run_red, run_green, run_blue
    logic        o_m_tlast;      // closes_line
    logic [0:0]  o_m_tuser;      // final_result
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    // Predictor state
    t_pixel      run_color;
    logic [7:0]  run_len;
    logic [7:0]  run_limit;
    t_result     expected_runs[$];

    int          mismatches  = 0;
    int          pixels_sent;
    int          cycle_count = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    bit          no_idle;

    rgb_run_length_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast),
        .o_m_tuser     (o_m_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Close the open run as one emitted run
    function automatic t_result close_run(input logic closes);
        t_result r;
        r.run_length   = run_len;
        r.run_red      = run_color.red;
        r.run_green    = run_color.green;
        r.run_blue     = run_color.blue;
        r.closes_line  = closes;
        r.final_result = 1'b0;
        return r;
    endfunction

    // Advance the run state by one pixel; return how many runs it emits
    function automatic int encode_pixel(input t_pixel p, input logic line_end,
                                        output t_result r0, output t_result r1);
        int n;
        n  = 0;
        r0 = '0;
        r1 = '0;
        if (run_len != 0 && p == run_color && run_len < run_limit) begin
            run_len = run_len + 8'd1;
        end else begin
            if (run_len != 0) begin
                r0 = close_run(1'b0);
                n  = 1;
            end
            run_color = p;
            run_len   = 8'd1;
        end
        // flush at end of line
        if (line_end) begin
            if (n == 0) r0 = close_run(1'b1);
            else        r1 = close_run(1'b1);
            n       = n + 1;
            run_len = 8'd0;
        end
        if (n == 1)      r0.final_result = 1'b1;
        else if (n == 2) r1.final_result = 1'b1;
        return n;
    endfunction

    // Offer one pixel request, wait for acceptance, then queue its runs
    task automatic send_pixel(input t_pixel p, input logic line_end,
                              input logic typed, input t_result typed_run);
        t_result r0, r1;
        int      n;
        while (!no_idle && $urandom_range(0, 99) < 6) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= p;
        i_s_tlast  <= line_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pixels_sent = pixels_sent + 1;
        n = encode_pixel(p, line_end, r0, r1);
        if (typed) begin
            expected_runs = {expected_runs, typed_run};
        end else begin
            if (n >= 1) expected_runs = {expected_runs, r0};
            if (n == 2) expected_runs = {expected_runs, r1};
        end
    endtask

    // Drop valid and wait until every expected run has left the block
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_run(input logic [7:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        run_limit = value;
    endtask

    // One limit setting: optional run past the limit, then bursts of colors
    task automatic encode_phase(input logic [7:0] limit, input int pixels,
                                input bit long_line);
        t_pixel palette [0:3];
        t_pixel p;
        int     k;
        int     span;
        int     burst;
        write_max_run(limit);
        for (k = 0; k < 4; k++) palette[k] = 24'($urandom);
        if (long_line) begin
            p = 24'($urandom);
            for (k = 0; k < limit + 5; k++) send_pixel(p, k == limit + 4, 1'b0, '0);
        end
        span = (limit > 40) ? 42 : limit + 2;
        k = 0;
        while (k < pixels) begin
            if ($urandom_range(0, 99) < 70) p = palette[$urandom_range(0, 3)];
            else                            p = 24'($urandom);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                                : $urandom_range(1, 4);
            repeat (burst) begin
                send_pixel(p, $urandom_range(0, 15) == 0, 1'b0, '0);
                k = k + 1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Check each accepted run against the oldest expectation
    always @(posedge i_clk) begin : check_runs
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser[0], o_m_tlast, o_m_tdata};
            if (expected_runs.size() == 0) begin
                $display("%0t: unexpected run, expected none, actual %h", $time, got);
                mismatches = mismatches + 1;
            end else begin
                want = expected_runs.pop_front();
                check_field("run_length",   want.run_length,   got.run_length);
                check_field("run_red",      want.run_red,      got.run_red);
                check_field("run_green",    want.run_green,    got.run_green);
                check_field("run_blue",     want.run_blue,     got.run_blue);
                check_field("closes_line",  {7'd0, want.closes_line},
                            {7'd0, got.closes_line});
                check_field("final_result", {7'd0, want.final_result},
                            {7'd0, got.final_result});
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && pixels_sent >= HOLD_AFTER) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            i_m_tready <= no_idle || ($urandom_range(0, 99) >= 6);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[rgb_run_length_encoder] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_pixel p;
        int     r;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        run_color     = '0;
        run_len       = 8'd0;
        run_limit     = MAX_RUN_RESET;
        pixels_sent   = 0;
        no_idle       = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (r = 0; r < NUM_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_MAX_RUN) begin
                write_max_run(directed_rows[r].max_run);
            end else begin
                p.red   = directed_rows[r].red;
                p.green = directed_rows[r].green;
                p.blue  = directed_rows[r].blue;
                send_pixel(p, directed_rows[r].line_end, directed_rows[r].typed,
                           directed_rows[r].run);
            end
        end

        // Random phases over several limits, extremes included
        encode_phase(8'd255, 150, 1'b1);
        encode_phase(8'd1, 130, 1'b0);
        encode_phase(8'd0, 100, 1'b0);
        no_idle = 1'b1;
        encode_phase(8'd2, 150, 1'b0);
        no_idle = 1'b0;
        encode_phase(8'd5, 150, 1'b0);
        encode_phase(8'd254, 60, 1'b1);
        encode_phase(8'($urandom_range(1, 255)), 150, 1'b0);

        wait_drained();
        if (mismatches == 0) begin
            $display("[rgb_run_length_encoder] OK");
        end else begin
            $display("[rgb_run_length_encoder] ERROR");
        end
        $finish;
    end

endmodule

@@ rgb_run_length_encoder.f @@
rtl/rgbrle_pkg.sv
rtl/rgbrle_run.sv
rtl/rgbrle_outq.sv
rtl/rgb_run_length_encoder.sv
sim/rgb_run_length_encoder_tb.sv
